/* src/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// shared types, codes and defaults for the positional list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // defaults for the top level parameters
  localparam int DEPTH_DEF      = 32;
  localparam int ITEM_WIDTH_DEF = 32;

  // fixed field widths
  localparam int POS_W  = 6;
  localparam int FUNC_W = 2;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;

  // operation codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

  // per-cycle command broadcast to every cell
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] pos;   // target index for insert or remove
    logic [POS_W-1:0] tail;  // index of the current tail, for rotate
  } ple_ctl_t;

endpackage

`default_nettype wire

/* src/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// one list slot; moves its word to or from its neighbors on command
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire ple_ctl_t              ctl,
  input  wire logic [ITEM_WIDTH-1:0] left_word,   // from the cell nearer the head
  input  wire logic [ITEM_WIDTH-1:0] right_word,  // from the cell nearer the tail
  input  wire logic [ITEM_WIDTH-1:0] new_word,    // insert data
  input  wire logic [ITEM_WIDTH-1:0] head_word,   // head wraps to the tail on rotate
  output logic      [ITEM_WIDTH-1:0] word
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [ITEM_WIDTH-1:0] word_r;
  logic [ITEM_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctl.mode)
      MODE_INSERT: begin
        if (MY_IDX == ctl.pos) begin
          word_nxt = new_word;
        end else if (MY_IDX > ctl.pos) begin
          word_nxt = left_word;
        end
      end
      MODE_REMOVE: begin
        if (MY_IDX >= ctl.pos) begin
          word_nxt = right_word;
        end
      end
      MODE_ROTATE: begin
        if (MY_IDX == ctl.tail) begin
          word_nxt = head_word;
        end else if (MY_IDX < ctl.tail) begin
          word_nxt = right_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

/* src/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list with insert / remove at an index and a full dump
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on the in_ stream: in_tuser is the operation (insert,
//   remove, dump), in_tdata carries the index and the word to insert.
//   results leave on the out_ stream, one per insert, remove or unused
//   code, one per entry on a dump (one result for an empty list); out_tlast
//   marks the final result of each request.
// sequencing:
//   one request is worked at a time. insert and remove go from accept to
//   the exec state, which loads the result register and shifts the whole
//   cell row once. a dump goes on from the exec state to the dump state,
//   where each step with a free result slot rotates the row by one cell and
//   sends the head word out, so after count steps the list is back in order.
// reset:
//   rst_n low clears the entry count, the state and the output valid; the
//   cell words are not cleared since cells beyond the count are never read.
// backpressure:
//   the result sits in an output register; while it waits with out_tready
//   low, the engine holds its command and the cells do not move. a new
//   request is taken as soon as the engine is idle, even with a result waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // pos [5:0], payload [37:6], zero pad [39:38]
  input  wire logic [1:0]  in_tuser,   // func [1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // entry_word [31:0], length [37:32], zero pad [39:38]
  output logic [1:0]       out_tuser,  // ok [0], has_entry [1]
  output logic             out_tlast   // last
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  // control
  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         dump_idx_r, dump_idx_nxt;

  // captured request
  logic [FUNC_W-1:0]     func_r;
  logic [POS_W-1:0]      pos_r;
  logic [ITEM_WIDTH-1:0] payload_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic                  out_has_r, out_has_nxt;
  logic [WORD_W-1:0]     out_word_r, out_word_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_req;
  logic                  slot_free;
  logic [CMP_W-1:0]      pos_cmp;
  logic [CMP_W-1:0]      count_cmp;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  dump_last;
  ple_ctl_t              ctl;

  logic [ITEM_WIDTH-1:0] cell_word [DEPTH];

  assign in_tready = (state_r == S_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign pos_cmp   = CMP_W'(pos_r);
  assign count_cmp = CMP_W'(count_r);
  assign ins_ok    = (count_r != CW'(DEPTH)) && (pos_cmp <= count_cmp);
  assign rem_ok    = (count_r != '0) && (pos_cmp < count_cmp);
  assign dump_last = (dump_idx_r == (count_r - CW'(1)));

  // request capture
  always_ff @(posedge clk) begin
    if (in_req) begin
      func_r    <= in_tuser;
      pos_r     <= in_tdata[5:0];
      payload_r <= ITEM_WIDTH'(in_tdata[37:6]);
    end
  end

  // sequencer: one request at a time; every result waits while the result slot is busy
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_has_nxt   = out_has_r;
    out_word_nxt  = out_word_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    ctl.mode      = MODE_HOLD;
    ctl.pos       = pos_r;
    ctl.tail      = POS_W'(count_r - CW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_r == FUNC_DUMP && count_r != '0) begin
          // nonempty dump streams from the rotating row
          dump_idx_nxt = '0;
          state_nxt    = S_DUMP;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = 1'b0;
          out_word_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          case (func_r)
            FUNC_INSERT: begin
              out_ok_nxt = ins_ok;
              if (ins_ok) begin
                ctl.mode  = MODE_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            FUNC_REMOVE: begin
              out_ok_nxt = rem_ok;
              if (rem_ok) begin
                ctl.mode  = MODE_REMOVE;
                count_nxt = count_r - CW'(1);
              end
            end
            FUNC_DUMP: begin
              // empty list
              out_ok_nxt = 1'b1;
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          out_len_nxt = LEN_W'(count_nxt);
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ctl.mode      = MODE_ROTATE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_has_nxt   = 1'b1;
          out_word_nxt  = WORD_W'(cell_word[0]);
          out_len_nxt   = LEN_W'(count_r);
          out_last_nxt  = dump_last;
          dump_idx_nxt  = dump_idx_r + CW'(1);
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_has_r  <= out_has_nxt;
    out_word_r <= out_word_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_w;
    logic [ITEM_WIDTH-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    ple_cell #(
      .IDX        (i),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .new_word   (payload_r),
      .head_word  (cell_word[0]),
      .word       (cell_word[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_word_r};
  assign out_tuser  = {out_has_r, out_ok_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* sim/tb_positional_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// drives insert, remove and dump requests into the list engine and checks
// every result against a queue-based shadow of the list, with random idling
// on both streams, a long result hold-off and a final back-to-back stretch
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 160;        // long result hold-off
  localparam int SETTLE_CYCLES = DEPTH + 8;  // a full dump plus margin
  localparam int MAX_REPORTS   = 40;
  localparam int TIMEOUT_NS    = 15_000_000;

  // one result as the engine reports it
  typedef struct packed {
    logic              ok;
    logic              has_entry;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  length;
    logic              last;
  } list_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // pos [5:0], payload [37:6], zero pad [39:38]
  logic [1:0]  in_tuser   = '0;  // func [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // entry_word [31:0], length [37:32], zero pad [39:38]
  logic [1:0]  out_tuser;        // ok [0], has_entry [1]
  logic        out_tlast;

  // shadow copy of the list, head at index 0
  logic [WORD_W-1:0] shadow_list[$];
  // results still owed by the engine, oldest first
  list_result_t      awaited_results[$];
  list_result_t      want_r;
  list_result_t      seen_r;

  int mismatch_count = 0;
  bit steady_input   = 1'b0;  // no gaps between requests
  bit steady_output  = 1'b0;  // no result stalls
  bit hold_results   = 1'b0;  // ask the result side for one long hold-off

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // ------------------------------------------------------------------
  // list prediction
  // ------------------------------------------------------------------

  // apply one accepted request to the shadow list and queue its results
  function automatic void predict_list_op(input logic [FUNC_W-1:0] func,
                                          input logic [POS_W-1:0]  pos,
                                          input logic [WORD_W-1:0] payload);
    int   n;
    logic ok_bit;
    n = shadow_list.size();
    if (func == FUNC_DUMP) begin
      // empty list still answers with one closing result
      if (n == 0)
        awaited_results.push_back('{1'b1, 1'b0, '0, '0, 1'b1});
      else
        for (int i = 0; i < n; i++)
          awaited_results.push_back('{1'b1, 1'b1, shadow_list[i], LEN_W'(n),
                                      (i == n - 1)});
    end else begin
      case (func)
        FUNC_INSERT: begin
          // pos may be anywhere from head to one past the tail
          ok_bit = (n < DEPTH) && (int'(pos) <= n);
          if (ok_bit) shadow_list.insert(int'(pos), payload);
        end
        FUNC_REMOVE: begin
          ok_bit = (n > 0) && (int'(pos) < n);
          if (ok_bit) shadow_list.delete(int'(pos));
        end
        default: ok_bit = 1'b0;  // unused code is refused
      endcase
      awaited_results.push_back('{ok_bit, 1'b0, '0, LEN_W'(shadow_list.size()), 1'b1});
    end
  endfunction

  // ------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------

  function automatic void check_field(input string what,
                                      input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] seen);
    if (want !== seen) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t %s expected %h actual %h", $time, what, want, seen);
    end
  endfunction

  // values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_r = '{out_tuser[0], out_tuser[1], out_tdata[31:0], out_tdata[37:32],
                 out_tlast};
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t result expected none actual %h", $time, seen_r);
      end else begin
        want_r = awaited_results.pop_front();
        check_field("ok", want_r.ok, seen_r.ok);
        check_field("has_entry", want_r.has_entry, seen_r.has_entry);
        check_field("entry_word", want_r.word, seen_r.word);
        check_field("length", want_r.length, seen_r.length);
        check_field("last", want_r.last, seen_r.last);
      end
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (!steady_output && $urandom_range(0, 5) == 0) begin
        // the loop's own edge closes the burst
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------

  // offer one request, wait for its handshake, then maybe idle a while
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [POS_W-1:0]  pos,
                              input logic [WORD_W-1:0] payload);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, payload, pos};
    do @(posedge clk); while (!in_tready);
    predict_list_op(func, pos, payload);
    if (!steady_input && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // stop offering and let every owed result come back
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // payload with a fair share of all-zero and all-one words
  function automatic logic [WORD_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly a legal index in 0..limit, sometimes any 6-bit value
  function automatic logic [POS_W-1:0] pick_pos(input int limit);
    if (limit >= 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, limit));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // random operation mix; hold_at picks the request where the long hold starts
  task automatic run_op_mix(input int count, input int hold_at);
    int n;
    int roll;
    int ins_pct;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_results = 1'b1;
      n       = shadow_list.size();
      roll    = $urandom_range(0, 99);
      // lean toward inserts on a short list, removes on a long one
      ins_pct = (n < DEPTH / 2) ? 50 : 32;
      if (roll < ins_pct)
        send_request(FUNC_INSERT, pick_pos(n), pick_payload());
      else if (roll < 82)
        send_request(FUNC_REMOVE, pick_pos(n - 1), pick_payload());
      else if (roll < 93)
        send_request(FUNC_DUMP, pick_pos(-1), pick_payload());
      else if (roll < 96)
        send_request(FUNC_SPARE, pick_pos(-1), pick_payload());
      else
        // any code, any index
        send_request(FUNC_W'($urandom_range(0, 3)), pick_pos(-1), $urandom());
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // empty list, head and tail inserts, bad indexes, unused code
  task automatic test_edge_cases();
    send_request(FUNC_REMOVE, 6'd0, 32'hDEAD_BEEF);   // remove on empty
    send_request(FUNC_DUMP, 6'd0, '0);                // dump of empty list
    send_request(FUNC_INSERT, 6'd1, 32'h0000_0001);   // past count on empty
    send_request(FUNC_INSERT, 6'd0, 32'hFFFF_FFFF);   // first entry
    send_request(FUNC_INSERT, 6'd1, 32'h0000_0000);   // append at tail
    send_request(FUNC_INSERT, 6'd0, 32'hA5A5_5A5A);   // head of non-empty list
    send_request(FUNC_INSERT, 6'd1, 32'h8000_0001);   // middle
    send_request(FUNC_INSERT, 6'h3F, 32'h1234_5678);  // far past the count
    send_request(FUNC_SPARE, 6'h2A, '1);              // unused code
    send_request(FUNC_DUMP, 6'h3F, '1);
    send_request(FUNC_REMOVE, 6'd3, '0);              // remove the tail
    send_request(FUNC_REMOVE, 6'd3, '0);              // index equal to count
    send_request(FUNC_REMOVE, 6'd0, '1);              // remove the head
    send_request(FUNC_REMOVE, 6'h3F, '0);             // far past the count
    send_request(FUNC_DUMP, 6'd0, '0);
    send_request(FUNC_REMOVE, 6'd1, '0);              // tail again
    send_request(FUNC_REMOVE, 6'd0, '0);              // list back to empty
    send_request(FUNC_DUMP, 6'd0, '0);
    finish_phase();
  endtask

  // fill to DEPTH, reject on full, dump the whole row, drain to empty
  task automatic test_fill_and_empty();
    while (shadow_list.size() < DEPTH)
      send_request(FUNC_INSERT, POS_W'($urandom_range(0, shadow_list.size())),
                   pick_payload());
    send_request(FUNC_INSERT, 6'd0, '1);              // full, at head
    send_request(FUNC_INSERT, POS_W'(DEPTH), '1);     // full, at tail
    send_request(FUNC_DUMP, 6'd0, '0);                // longest dump
    send_request(FUNC_SPARE, 6'd0, '0);
    while (shadow_list.size() > 0) begin
      send_request(FUNC_REMOVE, POS_W'($urandom_range(0, shadow_list.size() - 1)),
                   pick_payload());
      if ($urandom_range(0, 7) == 0) send_request(FUNC_DUMP, 6'd0, '0);
    end
    send_request(FUNC_REMOVE, 6'd0, '0);
    finish_phase();
  endtask

  task automatic test_random_mix();
    run_op_mix(150, -1);
    finish_phase();
  endtask

  // result side holds off long enough that the input stream stalls
  task automatic test_result_backpressure();
    run_op_mix(30, 4);
    finish_phase();
  endtask

  // no idling anywhere for the last stretch
  task automatic test_back_to_back();
    steady_input  = 1'b1;
    steady_output = 1'b1;
    run_op_mix(50, -1);
    finish_phase();
  endtask

  initial begin : run_tests
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_fill_and_empty();
    test_random_mix();
    test_result_backpressure();
    test_back_to_back();
    if (mismatch_count == 0)
      $display("positional_list_engine: match");
    else
      $display("positional_list_engine: mismatch");
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("positional_list_engine: mismatch");
    $finish;
  end

endmodule
